[design/itp_pkg.sv]
package itp_pkg;

  // Operator codes as held on the stack
  localparam logic [2:0] OpLparen = 3'd0;
  localparam logic [2:0] OpAdd    = 3'd1;
  localparam logic [2:0] OpSub    = 3'd2;
  localparam logic [2:0] OpMul    = 3'd3;
  localparam logic [2:0] OpDiv    = 3'd4;
  localparam logic [2:0] OpMod    = 3'd5;
  localparam logic [2:0] OpPow    = 3'd6;

  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChSpace  = 8'h20;

  // Results kept per input word; the rest are dropped
  localparam int unsigned MaxResults = 40;
  localparam int unsigned ResCntW    = 6;

  typedef struct packed {
    logic [7:0] in_char;
    logic       is_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       expr_done;
    logic       overflow;
  } out_word_t;

  // Sequencer to output stage
  typedef struct packed {
    logic       push_v;
    logic [7:0] push_char;
    logic       close_v;
    logic       close_last;
    logic       close_ovf;
  } emit_req_t;

  function automatic logic [2:0] op_code(input logic [7:0] ch);
    logic [2:0] code;
    case (ch)
      8'h2b:   code = OpAdd;
      8'h2d:   code = OpSub;
      8'h2a:   code = OpMul;
      8'h2f:   code = OpDiv;
      8'h25:   code = OpMod;
      8'h5e:   code = OpPow;
      default: code = OpLparen;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] op_char(input logic [2:0] code);
    logic [7:0] ch;
    case (code)
      OpLparen: ch = ChLparen;
      OpAdd:    ch = 8'h2b;
      OpSub:    ch = 8'h2d;
      OpMul:    ch = 8'h2a;
      OpDiv:    ch = 8'h2f;
      OpMod:    ch = 8'h25;
      OpPow:    ch = 8'h5e;
      default:  ch = ChSpace;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] op_prec(input logic [2:0] code);
    logic [1:0] p;
    case (code)
      OpAdd, OpSub:        p = 2'd1;
      OpMul, OpDiv, OpMod: p = 2'd2;
      OpPow:               p = 2'd3;
      default:             p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

[design/infix_to_postfix_converter.sv]
// Channel | Dir | Handshake                | Word
// in      | in  | in_valid_i / in_ready_o  | itp_pkg::in_word_t  (in_char, is_end)
// out     | out | out_valid_o / out_ready_i| itp_pkg::out_word_t (out_char, char_valid,
//         |     |                          |   expr_done, overflow)
//
// One input word at a time: accept, classify, then for each popped operator a
// stack read, then the operator byte and a space, paced by the synchronous
// read of the operator stack memory and one output byte per cycle unless stalled.
// A final word adds a space after a trailing number, then an operator byte and a
// space per flushed operator, and drops each stray '(' silently.
// Reset clears the stack pointer, the number flag and the overflow flag.
// A stalled output holds the sequencer where it stands; no byte is lost.
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  itp_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output itp_pkg::out_word_t  out_word_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  // One-hot sequencer
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,  // wait for a word
    S_CLASS  = 7'b0000010,  // classify the byte, end any pending number
    S_POPCHK = 7'b0000100,  // stack top is in, decide pop or stop
    S_POPSP  = 7'b0001000,  // space after a popped operator
    S_END    = 7'b0010000,  // close the word, or drive the flush on the last one
    S_FLCHK  = 7'b0100000,  // flush: stack top is in
    S_FLSP   = 7'b1000000   // flush: space after an operator
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     count_m1;
  logic              in_num_q, in_num_d;
  logic              ovf_q, ovf_d;
  logic [7:0]        char_q;
  logic              end_q;
  logic [2:0]        code_q;
  logic              is_close_q;

  // Operator stack: synchronous memory, one write and one read port
  logic [2:0]        stack_mem [STACK_DEPTH];
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [2:0]        wr_data;
  logic [2:0]        top_q;

  itp_pkg::emit_req_t req;
  logic               push_ok, close_ok;
  logic               is_num, pop_cond;

  assign count_m1 = count_q - CW'(1);
  assign rd_addr  = count_m1[AW-1:0];
  assign wr_addr  = count_q[AW-1:0];

  assign is_num   = ((char_q >= 8'h30) && (char_q <= 8'h39)) || (char_q == itp_pkg::ChDot);
  assign pop_cond = is_close_q ? (top_q != itp_pkg::OpLparen)
                               : (itp_pkg::op_prec(top_q) >= itp_pkg::op_prec(code_q));

  // A push is only ever read back after its write has landed, as the
  // read of the top is issued from a later state; no forwarding is needed.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    in_num_d = in_num_q;
    ovf_d   = ovf_q;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_data = code_q;
    req     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CLASS;
        end
      end

      S_CLASS: begin
        if (is_num) begin
          // copy digit or dot straight through
          req.push_v    = 1'b1;
          req.push_char = char_q;
          if (push_ok) begin
            in_num_d = 1'b1;
            state_d  = S_END;
          end
        end else if (in_num_q) begin
          // terminate the pending number first
          req.push_v    = 1'b1;
          req.push_char = itp_pkg::ChSpace;
          if (push_ok) begin
            in_num_d = 1'b0;
          end
        end else if (char_q == itp_pkg::ChLparen) begin
          wr_data = itp_pkg::OpLparen;
          if (count_q == CW'(STACK_DEPTH)) begin
            ovf_d = 1'b1;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
          end
          state_d = S_END;
        end else if (is_close_q || (code_q != itp_pkg::OpLparen)) begin
          if (count_q != '0) begin
            rd_en   = 1'b1;
            state_d = S_POPCHK;
          end else begin
            if (!is_close_q) begin
              wr_en   = 1'b1;
              count_d = count_q + CW'(1);
            end
            state_d = S_END;
          end
        end else begin
          state_d = S_END;
        end
      end

      S_POPCHK: begin
        if (pop_cond) begin
          req.push_v    = 1'b1;
          req.push_char = itp_pkg::op_char(top_q);
          if (push_ok) begin
            count_d = count_m1;
            state_d = S_POPSP;
          end
        end else begin
          if (is_close_q) begin
            // drop the matching bracket
            count_d = count_m1;
          end else if (count_q == CW'(STACK_DEPTH)) begin
            ovf_d = 1'b1;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
          end
          state_d = S_END;
        end
      end

      S_POPSP: begin
        req.push_v    = 1'b1;
        req.push_char = itp_pkg::ChSpace;
        if (push_ok) begin
          if (count_q != '0) begin
            rd_en   = 1'b1;
            state_d = S_POPCHK;
          end else begin
            // stack empty: the pops cannot have left it full
            if (!is_close_q) begin
              wr_en   = 1'b1;
              count_d = count_q + CW'(1);
            end
            state_d = S_END;
          end
        end
      end

      S_END: begin
        if (!end_q) begin
          req.close_v = 1'b1;
          if (close_ok) begin
            state_d = S_IDLE;
          end
        end else if (in_num_q) begin
          req.push_v    = 1'b1;
          req.push_char = itp_pkg::ChSpace;
          if (push_ok) begin
            in_num_d = 1'b0;
          end
        end else if (count_q != '0) begin
          rd_en   = 1'b1;
          state_d = S_FLCHK;
        end else begin
          req.close_v    = 1'b1;
          req.close_last = 1'b1;
          req.close_ovf  = ovf_q;
          if (close_ok) begin
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end
        end
      end

      S_FLCHK: begin
        if (top_q != itp_pkg::OpLparen) begin
          req.push_v    = 1'b1;
          req.push_char = itp_pkg::op_char(top_q);
          if (push_ok) begin
            count_d = count_m1;
            state_d = S_FLSP;
          end
        end else begin
          // unmatched bracket: discard silently
          count_d = count_m1;
          state_d = S_END;
        end
      end

      S_FLSP: begin
        req.push_v    = 1'b1;
        req.push_char = itp_pkg::ChSpace;
        if (push_ok) begin
          state_d = S_END;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      in_num_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      in_num_q <= in_num_d;
      ovf_q    <= ovf_d;
    end
  end

  // Latch the accepted word and its decode
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q     <= in_word_i.in_char;
      end_q      <= in_word_i.is_end;
      code_q     <= itp_pkg::op_code(in_word_i.in_char);
      is_close_q <= (in_word_i.in_char == itp_pkg::ChRparen);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      top_q <= stack_mem[rd_addr];
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  itp_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .push_ok_o   (push_ok),
    .close_ok_o  (close_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

[design/itp_emit.sv]
module itp_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itp_pkg::emit_req_t   req_i,
  output logic                 push_ok_o,
  output logic                 close_ok_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output itp_pkg::out_word_t   out_word_o
);

  logic                         pend_v_q, pend_v_d;
  logic [7:0]                   pend_char_q, pend_char_d;
  logic [itp_pkg::ResCntW-1:0]  cnt_q, cnt_d;
  logic                         out_v_q, out_v_d;
  itp_pkg::out_word_t           out_q, out_d;
  logic                         out_free, drop, move;

  assign out_free   = !out_v_q || out_ready_i;
  assign drop       = cnt_q >= itp_pkg::ResCntW'(itp_pkg::MaxResults);
  assign push_ok_o  = drop || !pend_v_q || out_free;
  assign close_ok_o = out_free || (!pend_v_q && !req_i.close_last);

  // Hold the newest byte back until it is known whether it closes the expression
  always_comb begin
    pend_v_d    = pend_v_q;
    pend_char_d = pend_char_q;
    cnt_d       = cnt_q;
    move        = 1'b0;
    out_d       = out_q;
    if (req_i.push_v && !drop && push_ok_o) begin
      if (pend_v_q) begin
        move  = 1'b1;
        out_d = '{out_char: pend_char_q, char_valid: 1'b1, expr_done: 1'b0, overflow: 1'b0};
      end
      pend_v_d    = 1'b1;
      pend_char_d = req_i.push_char;
      cnt_d       = cnt_q + itp_pkg::ResCntW'(1);
    end
    if (req_i.close_v && close_ok_o) begin
      cnt_d    = '0;
      pend_v_d = 1'b0;
      if (req_i.close_last) begin
        move  = 1'b1;
        out_d = '{out_char:   pend_v_q ? pend_char_q : 8'h00,
                  char_valid: pend_v_q,
                  expr_done:  1'b1,
                  overflow:   req_i.close_ovf};
      end else if (pend_v_q) begin
        move  = 1'b1;
        out_d = '{out_char: pend_char_q, char_valid: 1'b1, expr_done: 1'b0, overflow: 1'b0};
      end
    end
    if (move) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      cnt_q    <= '0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      cnt_q    <= cnt_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_char_q <= pend_char_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

endmodule

[design/itp_checker.sv]
module itp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input itp_pkg::out_word_t out_word_o
);

  // An empty result only ever closes an expression, and carries a zero byte
  a_empty_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.char_valid) |->
      (out_word_o.expr_done && (out_word_o.out_char == 8'h00)))
    else $error("empty result not final or byte not zero");

  // Overflow is reported on the final result alone
  a_ovf_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.overflow) |-> out_word_o.expr_done)
    else $error("overflow on a non-final result");

  // Words are taken one at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready straight after an accept");

  // Stalled output holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled output word changed");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
